[rtl/core/kmefp_pkg.sv]
// ----------------------------------------------------------------------------
// kmefp_pkg
// Shared types and constants of the keyboard / mouse event FIFO port.
// ----------------------------------------------------------------------------
package kmefp_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;

	localparam logic [1:0] ACT_KEY   = 2'd0;
	localparam logic [1:0] ACT_MOUSE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_WRITE = 2'd3;

	localparam logic [7:0] PORT_KEY   = 8'h10;
	localparam logic [7:0] PORT_MOUSE = 8'h11;

	localparam int KEY_W   = 8;
	localparam int MOUSE_W = 32;

	typedef struct packed {
		logic [1:0]        action;
		logic [5:0]        key_code;
		logic              key_released;
		logic signed [7:0] motion_x;
		logic signed [7:0] motion_y;
		logic [15:0]       button_bits;
		logic [7:0]        port_number;
	} in_word_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        read_handled;
		logic        key_irq;
		logic        mouse_irq;
	} out_word_t;

	typedef struct packed {
		logic exec;
		logic load_data;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pop_hit;
	} dp_sts_t;

endpackage

[rtl/core/kmefp_ram.sv]
// ----------------------------------------------------------------------------
// kmefp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmefp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/kmefp_ctrl.sv]
// ----------------------------------------------------------------------------
// kmefp_ctrl
// Controller: accept a word, wait on a queue read, hold the result word.
// ----------------------------------------------------------------------------
module kmefp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  kmefp_pkg::dp_sts_t   sts,
	output kmefp_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d       = state_q;
		cmd.exec      = 1'b0;
		cmd.load_data = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.exec = 1'b1;
					state_d  = sts.pop_hit ? S_READ : S_OUT;
				end
			end
			S_READ: begin
				cmd.load_data = 1'b1;
				state_d       = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

endmodule

[rtl/core/kmefp_dp.sv]
// ----------------------------------------------------------------------------
// kmefp_dp
// Datapath: queue pointers, key and mouse event queues, result word register.
// ----------------------------------------------------------------------------
module kmefp_dp #(
	parameter int QUEUE_DEPTH = kmefp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kmefp_pkg::in_word_t  in_word,
	input  kmefp_pkg::ctrl_cmd_t cmd,
	output kmefp_pkg::dp_sts_t   sts,
	output kmefp_pkg::out_word_t out_word
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
		return (p == LAST) ? '0 : p + PTR_W'(1);
	endfunction

	logic [PTR_W-1:0] key_head_q, key_tail_q, mouse_head_q, mouse_tail_q;
	logic [PTR_W-1:0] key_tail_nx, mouse_tail_nx;
	logic             is_key, is_mouse, rd_key, rd_mouse, pop_key, pop_mouse;
	logic             sel_mouse_q;
	logic [kmefp_pkg::KEY_W-1:0]   key_byte, key_rdata;
	logic [kmefp_pkg::MOUSE_W-1:0] mouse_wordv, mouse_rdata;
	kmefp_pkg::out_word_t          res_q;

	assign is_key   = (in_word.action == kmefp_pkg::ACT_KEY);
	assign is_mouse = (in_word.action == kmefp_pkg::ACT_MOUSE);
	assign rd_key   = (in_word.action == kmefp_pkg::ACT_READ)
	                  && (in_word.port_number == kmefp_pkg::PORT_KEY);
	assign rd_mouse = (in_word.action == kmefp_pkg::ACT_READ)
	                  && (in_word.port_number == kmefp_pkg::PORT_MOUSE);
	assign pop_key   = rd_key && (key_head_q != key_tail_q);
	assign pop_mouse = rd_mouse && (mouse_head_q != mouse_tail_q);
	assign sts.pop_hit = pop_key || pop_mouse;

	assign key_byte = in_word.key_released
	                  ? (8'd0 - {2'b00, in_word.key_code})
	                  : {2'b00, in_word.key_code};
	assign mouse_wordv = {in_word.button_bits, in_word.motion_y, in_word.motion_x};

	assign key_tail_nx   = adv(key_tail_q);
	assign mouse_tail_nx = adv(mouse_tail_q);

	kmefp_ram #(
		.WIDTH (kmefp_pkg::KEY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_key_ram (
		.clk   (clk),
		.we    (cmd.exec && is_key),
		.waddr (key_tail_q),
		.wdata (key_byte),
		.re    (cmd.exec && pop_key),
		.raddr (key_head_q),
		.rdata (key_rdata)
	);

	kmefp_ram #(
		.WIDTH (kmefp_pkg::MOUSE_W),
		.DEPTH (QUEUE_DEPTH)
	) u_mouse_ram (
		.clk   (clk),
		.we    (cmd.exec && is_mouse),
		.waddr (mouse_tail_q),
		.wdata (mouse_wordv),
		.re    (cmd.exec && pop_mouse),
		.raddr (mouse_head_q),
		.rdata (mouse_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_head_q   <= '0;
			key_tail_q   <= '0;
			mouse_head_q <= '0;
			mouse_tail_q <= '0;
		end else if (cmd.exec) begin
			if (is_key) begin
				if (key_tail_nx == key_head_q) begin
					key_head_q <= '0;
					key_tail_q <= '0;
				end else begin
					key_tail_q <= key_tail_nx;
				end
			end
			if (is_mouse) begin
				if (mouse_tail_nx == mouse_head_q) begin
					mouse_head_q <= '0;
					mouse_tail_q <= '0;
				end else begin
					mouse_tail_q <= mouse_tail_nx;
				end
			end
			if (pop_key) begin
				key_head_q <= adv(key_head_q);
			end
			if (pop_mouse) begin
				mouse_head_q <= adv(mouse_head_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q.read_data    <= '0;
			res_q.read_handled <= rd_key || rd_mouse;
			res_q.key_irq      <= is_key;
			res_q.mouse_irq    <= is_mouse;
			sel_mouse_q        <= rd_mouse;
		end else if (cmd.load_data) begin
			res_q.read_data <= sel_mouse_q ? mouse_rdata : {24'd0, key_rdata};
		end
	end

	assign out_word = res_q;

endmodule

[rtl/core/keyboard_mouse_event_fifo_port_top.sv]
// ----------------------------------------------------------------------------
// keyboard_mouse_event_fifo_port_top
// Keyboard and mouse event queues with a bus read port that pops them.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | word
//  input   | in_valid  | in_stall  | in_word  (kmefp_pkg::in_word_t)
//  output  | out_valid | out_stall | out_word (kmefp_pkg::out_word_t)
//
//  An event, a write or a read that finds nothing to pop presents its result
//  in the cycle after accept; a read that pops passes through S_READ first,
//  for the registered queue RAM read, and is presented from S_OUT. One word
//  is in flight at a time; the next is accepted in the cycle after the result
//  is taken. in_stall stays high while a result waits. Reset empties both
//  queues at once, with no clearing pass.
// ----------------------------------------------------------------------------
module keyboard_mouse_event_fifo_port_top #(
	parameter int QUEUE_DEPTH = kmefp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  kmefp_pkg::in_word_t  in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output kmefp_pkg::out_word_t out_word
);

	kmefp_pkg::ctrl_cmd_t cmd;
	kmefp_pkg::dp_sts_t   sts;

	kmefp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	kmefp_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.cmd      (cmd),
		.sts      (sts),
		.out_word (out_word)
	);

endmodule

[tb/sv/keyboard_mouse_event_fifo_port_top_tb.sv]
// ----------------------------------------------------------------------------
// keyboard_mouse_event_fifo_port_top_tb
// Drives key events, mouse events and bus accesses into the event FIFO port.
// Each accepted word is run through a local model of both event rings, and
// the result that the model gives is queued. Every result taken from the block
// is compared field by field with the oldest queued one. Both handshake sides
// idle in random bursts, and the result side holds off once for a long
// stretch so that the block backs up.
// ----------------------------------------------------------------------------
module keyboard_mouse_event_fifo_port_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kmefp_pkg::*;

	localparam int DEPTH       = QUEUE_DEPTH_DEF;
	localparam int ITEM_TARGET = 400;
	localparam int QUIET_TAIL  = 60;
	localparam int HOLD_AT     = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 8;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_word_t  in_word   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_word;

	keyboard_mouse_event_fifo_port_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	in_word_t    stimulus_words[$];
	out_word_t   awaited_responses[$];
	logic [7:0]  key_ring   [DEPTH];
	logic [31:0] mouse_ring [DEPTH];
	int          key_rd         = 0;
	int          key_wr         = 0;
	int          mouse_rd       = 0;
	int          mouse_wr       = 0;
	int          mismatches     = 0;
	int          responses_seen = 0;
	int          counted_items  = 0;
	int          in_gap         = 0;
	int          out_gap        = 0;
	int          hold_left      = 0;
	bit          hold_done      = 1'b0;
	logic        tail_quiet     = 1'b0;

	initial forever #2 clk = ~clk;

	function automatic int next_slot(int p);
		return (p + 1) % DEPTH;
	endfunction

	function automatic out_word_t port_response(in_word_t w);
		out_word_t r;
		r = '0;
		case (w.action)
			ACT_KEY: begin
				key_ring[key_wr] = w.key_released ? (8'h00 - {2'b00, w.key_code})
					: {2'b00, w.key_code};
				key_wr = next_slot(key_wr);
				if (key_wr == key_rd) begin
					key_wr = 0;
					key_rd = 0;
				end
				r.key_irq = 1'b1;
			end
			ACT_MOUSE: begin
				mouse_ring[mouse_wr] = {w.button_bits, w.motion_y, w.motion_x};
				mouse_wr = next_slot(mouse_wr);
				if (mouse_wr == mouse_rd) begin
					mouse_wr = 0;
					mouse_rd = 0;
				end
				r.mouse_irq = 1'b1;
			end
			ACT_READ: begin
				if (w.port_number == PORT_KEY) begin
					r.read_handled = 1'b1;
					if (key_rd != key_wr) begin
						r.read_data = {24'h000000, key_ring[key_rd]};
						key_rd = next_slot(key_rd);
					end
				end else if (w.port_number == PORT_MOUSE) begin
					r.read_handled = 1'b1;
					if (mouse_rd != mouse_wr) begin
						r.read_data = mouse_ring[mouse_rd];
						mouse_rd = next_slot(mouse_rd);
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic in_word_t make_word(logic [1:0] act, logic [7:0] port);
		in_word_t w;
		w.action       = act;
		w.key_code     = 6'($urandom);
		w.key_released = 1'($urandom);
		w.motion_x     = 8'($urandom);
		w.motion_y     = 8'($urandom);
		w.button_bits  = 16'($urandom);
		w.port_number  = port;
		return w;
	endfunction

	function automatic in_word_t key_word(logic [5:0] code, logic rel);
		in_word_t w;
		w = make_word(ACT_KEY, 8'($urandom));
		w.key_code     = code;
		w.key_released = rel;
		return w;
	endfunction

	function automatic in_word_t mouse_word(logic [7:0] x, logic [7:0] y, logic [15:0] btn);
		in_word_t w;
		w = make_word(ACT_MOUSE, 8'($urandom));
		w.motion_x    = x;
		w.motion_y    = y;
		w.button_bits = btn;
		return w;
	endfunction

	function automatic logic [7:0] handled_port();
		return $urandom_range(0, 1) ? PORT_KEY : PORT_MOUSE;
	endfunction

	function automatic in_word_t mixed_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			return make_word(ACT_KEY, 8'($urandom));
		else if (pick < 55)
			return make_word(ACT_MOUSE, 8'($urandom));
		else if (pick < 85)
			return make_word(ACT_READ, handled_port());
		else if (pick < 90)
			return make_word(ACT_READ, 8'($urandom));
		return make_word(ACT_WRITE, 8'($urandom));
	endfunction

	function automatic void queue_word(in_word_t w);
		stimulus_words.push_back(w);
		if (w.action == ACT_KEY || w.action == ACT_MOUSE ||
				(w.action == ACT_READ &&
				(w.port_number == PORT_KEY || w.port_number == PORT_MOUSE)))
			counted_items++;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			tail_quiet <= 1'b0;
			in_gap = 0;
		end else begin
			tail_quiet <= stimulus_words.size() < QUIET_TAIL;
			if (!in_valid || !in_stall) begin
				if (in_gap == 0 && stimulus_words.size() >= QUIET_TAIL &&
						$urandom_range(0, 9) == 0)
					in_gap = $urandom_range(1, 16);
				if (in_gap > 0) begin
					in_gap = in_gap - 1;
					in_valid <= 1'b0;
				end else if (stimulus_words.size() > 0) begin
					in_valid <= 1'b1;
					in_word  <= stimulus_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (!hold_done && responses_seen >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (tail_quiet) begin
			out_stall <= 1'b0;
		end else begin
			if (out_gap == 0 && $urandom_range(0, 7) == 0)
				out_gap = $urandom_range(1, 16);
			if (out_gap > 0) begin
				out_gap = out_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				awaited_responses.push_back(port_response(in_word));
			if (out_valid && !out_stall) begin
				responses_seen <= responses_seen + 1;
				if (awaited_responses.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word, expected none, actual %h", $time, out_word);
				end else begin
					want = awaited_responses.pop_front();
					if (out_word.read_data !== want.read_data) begin
						mismatches++;
						$display("%0t: read_data expected %h actual %h",
							$time, want.read_data, out_word.read_data);
					end
					if (out_word.read_handled !== want.read_handled) begin
						mismatches++;
						$display("%0t: read_handled expected %b actual %b",
							$time, want.read_handled, out_word.read_handled);
					end
					if (out_word.key_irq !== want.key_irq) begin
						mismatches++;
						$display("%0t: key_irq expected %b actual %b",
							$time, want.key_irq, out_word.key_irq);
					end
					if (out_word.mouse_irq !== want.mouse_irq) begin
						mismatches++;
						$display("%0t: mouse_irq expected %b actual %b",
							$time, want.mouse_irq, out_word.mouse_irq);
					end
				end
			end
		end
	end

	initial begin
		int         seg;
		int         n;
		logic [1:0] act;
		logic [7:0] port;

		foreach (key_ring[i])
			key_ring[i] = '0;
		foreach (mouse_ring[i])
			mouse_ring[i] = '0;

		queue_word(make_word(ACT_READ, PORT_KEY));
		queue_word(make_word(ACT_READ, PORT_MOUSE));
		queue_word(key_word(6'd0, 1'b0));
		queue_word(key_word(6'd0, 1'b1));
		queue_word(key_word(6'd63, 1'b0));
		queue_word(key_word(6'd63, 1'b1));
		queue_word(key_word(6'd1, 1'b1));
		queue_word(key_word(6'd1, 1'b0));
		queue_word(mouse_word(8'h80, 8'h7f, 16'hffff));
		queue_word(mouse_word(8'h7f, 8'h80, 16'h0000));
		queue_word(mouse_word(8'h00, 8'h00, 16'h0000));
		repeat (7)
			queue_word(make_word(ACT_READ, PORT_KEY));
		repeat (4)
			queue_word(make_word(ACT_READ, PORT_MOUSE));
		queue_word(make_word(ACT_READ, 8'h12));
		queue_word(make_word(ACT_READ, 8'hff));
		queue_word(make_word(ACT_WRITE, PORT_KEY));
		queue_word(make_word(ACT_WRITE, 8'hff));

		while (counted_items < ITEM_TARGET) begin
			seg = $urandom_range(0, 9);
			if (seg < 2) begin
				act  = (seg == 0) ? ACT_KEY : ACT_MOUSE;
				port = (seg == 0) ? PORT_KEY : PORT_MOUSE;
				n = $urandom_range(20, 40);
				repeat (n)
					queue_word(make_word(act, 8'($urandom)));
				n = $urandom_range(5, 40);
				repeat (n)
					queue_word(make_word(ACT_READ, port));
			end else if (seg < 4) begin
				n = $urandom_range(1, 8);
				repeat (n)
					queue_word(make_word(ACT_READ, handled_port()));
			end else begin
				n = $urandom_range(1, 10);
				repeat (n)
					queue_word(mixed_word());
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stimulus_words.size() != 0 || in_valid || awaited_responses.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#1ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
